// File: hw/rtl/sams_pkg.sv
// ----------------------------------------------------------------------------
// Servo axis motion sequencer package
// Sequencer codes, command bit masks, configuration indexes, reset values and
// the per-axis record that is kept in the state memory.
// ----------------------------------------------------------------------------
package sams_pkg;

    localparam int AXIS_COUNT_DEFAULT = 4;

    // Sequencer state codes.
    localparam logic [3:0] ST_WAIT     = 4'd0;
    localparam logic [3:0] ST_POWER    = 4'd1;
    localparam logic [3:0] ST_INITHOME = 4'd2;
    localparam logic [3:0] ST_READY    = 4'd3;
    localparam logic [3:0] ST_HOME     = 4'd4;
    localparam logic [3:0] ST_STOP     = 4'd5;
    localparam logic [3:0] ST_JOGP     = 4'd6;
    localparam logic [3:0] ST_JOGN     = 4'd7;
    localparam logic [3:0] ST_ABS      = 4'd8;
    localparam logic [3:0] ST_REL      = 4'd9;
    localparam logic [3:0] ST_ERROR    = 4'd10;
    localparam logic [3:0] ST_ERRRESET = 4'd11;

    // Pending user command bits.
    localparam logic [4:0] PC_HOME = 5'h01;
    localparam logic [4:0] PC_STOP = 5'h02;
    localparam logic [4:0] PC_ABS  = 5'h04;
    localparam logic [4:0] PC_REL  = 5'h08;
    localparam logic [4:0] PC_ACK  = 5'h10;

    // Command bits toward the drive.
    localparam logic [6:0] DC_POWER = 7'h01;
    localparam logic [6:0] DC_HOME  = 7'h02;
    localparam logic [6:0] DC_STOP  = 7'h04;
    localparam logic [6:0] DC_ABS   = 7'h08;
    localparam logic [6:0] DC_ADD   = 7'h10;
    localparam logic [6:0] DC_VEL   = 7'h20;
    localparam logic [6:0] DC_ACK   = 7'h40;

    // Jog level bits.
    localparam logic [1:0] JOG_POS = 2'b01;
    localparam logic [1:0] JOG_NEG = 2'b10;

    // Configuration register indexes.
    localparam logic [2:0] CFG_POWER_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_JOG_MOVE_SPEED = 3'd1;
    localparam logic [2:0] CFG_ACCELERATION   = 3'd2;
    localparam logic [2:0] CFG_DECELERATION   = 3'd3;
    localparam logic [2:0] CFG_HOMING_REF     = 3'd4;
    localparam logic [2:0] CFG_ACK_TIMEOUT    = 3'd5;

    localparam int CFG_DATA_W = 24;

    // Reset values and fixed numbers.
    localparam logic [15:0] SPEED_DEFAULT    = 16'd3000;
    localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd200;
    localparam logic [7:0]  ACK_COUNT_MAX    = 8'd255;

    // One axis worth of sequencer state.
    typedef struct packed {
        logic [3:0]         seq;
        logic [4:0]         pend;
        logic [6:0]         dcmd;
        logic signed [16:0] speed;
        logic signed [31:0] pos;
        logic [15:0]        err;
        logic [7:0]         ack;
        logic               homed;
    } axis_rec_t;

    localparam int REC_W = $bits(axis_rec_t);

endpackage

// File: hw/rtl/servo_axis_motion_sequencer.sv
// ----------------------------------------------------------------------------
// Servo axis motion sequencer
// Per-axis motion state machine with its state held in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// Each input word is one control tick for one axis: user command pulses, jog
// levels, a target position and the drive status. Each tick for an axis
// below AXIS_COUNT yields exactly one output word with the axis state, the
// command bits, speed and position toward the drive, and status flags.
// Ticks for an axis at or above AXIS_COUNT are taken and dropped.
// The state memory is read on the accepting edge, and the updated record
// lands in the output register when the compute stage advances, which it
// does unless the receiver stalls a word already held at the output.
// A new word is taken every cycle while in_stall is low; a tick that
// follows a tick of the same axis picks up the just-written record through
// a forwarding register. When the receiver stalls, the output word holds and
// the input side stalls only once the compute stage is also occupied.
// After reset every axis reads as being in the wait state with all fields
// zero; per-entry valid bits supply that, so no clearing pass is needed.
// Configuration writes take effect at once; the user must make them only while
// idle; the block does not check. Accel/decel registers have no effect.
// ----------------------------------------------------------------------------
module servo_axis_motion_sequencer
    import sams_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            axis,
    input  logic [4:0]            command_pulses,
    input  logic [1:0]            jog_levels,
    input  logic signed [31:0]    target_position,
    input  logic                  drive_initialized,
    input  logic                  drive_powered,
    input  logic                  drive_homed,
    input  logic                  drive_moving,
    input  logic [15:0]           drive_error_code,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            axis_out,
    output logic [3:0]            sequencer_state,
    output logic [6:0]            drive_commands,
    output logic signed [16:0]    drive_speed,
    output logic signed [31:0]    drive_position,
    output logic [15:0]           error_code,
    output logic                  axis_ready,
    output logic                  home_done
);

    localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

    // Configuration registers.
    logic        power_enable_reg;
    logic [15:0] jog_move_speed_reg;
    logic        homing_ref_reg;
    logic [7:0]  ack_timeout_reg;

    // State memory and per-entry valid bits.
    axis_rec_t           mem [AXIS_COUNT];
    axis_rec_t           mem_q;
    logic [AXIS_COUNT-1:0] entry_valid_reg;

    // Compute stage registers.
    logic               s1_valid_reg;
    logic [1:0]         s1_axis_reg;
    logic [4:0]         s1_pulses_reg;
    logic [1:0]         s1_jog_reg;
    logic signed [31:0] s1_target_reg;
    logic               s1_inited_reg;
    logic               s1_powered_reg;
    logic               s1_homed_reg;
    logic               s1_moving_reg;
    logic [15:0]        s1_status_reg;

    // Forwarding register: the record written on the last edge.
    logic               fw_valid_reg;
    logic [AW-1:0]      fw_addr_reg;
    axis_rec_t          fw_rec_reg;

    logic               out_valid_reg;

    logic               in_accept;
    logic               in_range;
    logic               s1_adv;
    logic               s1_fire;
    logic [AW-1:0]      in_addr;
    logic [AW-1:0]      s1_addr;
    logic [AW-1:0]      rd_addr;
    axis_rec_t          cur_rec;
    axis_rec_t          rec_next;
    logic               ready_next;

    assign in_addr   = AW'(axis);
    assign s1_addr   = AW'(s1_axis_reg);
    assign in_range  = (int'(axis) < AXIS_COUNT);
    assign s1_adv    = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign rd_addr   = in_accept ? in_addr : s1_addr;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_enable_reg   <= 1'b1;
            jog_move_speed_reg <= SPEED_DEFAULT;
            homing_ref_reg     <= 1'b0;
            ack_timeout_reg    <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POWER_ENABLE:   power_enable_reg   <= cfg_data[0];
                CFG_JOG_MOVE_SPEED: jog_move_speed_reg <= cfg_data[15:0];
                CFG_HOMING_REF:     homing_ref_reg     <= cfg_data[0];
                CFG_ACK_TIMEOUT:    ack_timeout_reg    <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // Synchronous state memory: one read and one write port.
    always_ff @(posedge clk)
    begin
        mem_q <= mem[rd_addr];
        if (s1_fire)
        begin
            mem[s1_addr] <= rec_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            fw_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                entry_valid_reg[s1_addr] <= 1'b1;
            end
            fw_valid_reg <= s1_fire;
            if (in_accept && in_range)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_axis_reg    <= axis;
            s1_pulses_reg  <= command_pulses;
            s1_jog_reg     <= jog_levels;
            s1_target_reg  <= target_position;
            s1_inited_reg  <= drive_initialized;
            s1_powered_reg <= drive_powered;
            s1_homed_reg   <= drive_homed;
            s1_moving_reg  <= drive_moving;
            s1_status_reg  <= drive_error_code;
        end
        if (s1_fire)
        begin
            fw_addr_reg     <= s1_addr;
            fw_rec_reg      <= rec_next;
            axis_out        <= s1_axis_reg;
            sequencer_state <= rec_next.seq;
            drive_commands  <= rec_next.dcmd;
            drive_speed     <= rec_next.speed;
            drive_position  <= rec_next.pos;
            error_code      <= rec_next.err;
            axis_ready      <= ready_next;
            home_done       <= rec_next.homed;
        end
    end

    // The memory read misses a write made on the same edge, so the most
    // recent write is taken from the forwarding register instead.
    always_comb
    begin
        if (fw_valid_reg && (fw_addr_reg == s1_addr))
        begin
            cur_rec = fw_rec_reg;
        end
        else if (!entry_valid_reg[s1_addr])
        begin
            cur_rec = '0;
        end
        else
        begin
            cur_rec = mem_q;
        end
    end

    // Next state of the axis.
    always_comb
    begin
        logic signed [16:0] spd;
        logic [4:0]         pc;
        logic [6:0]         dc;
        logic [3:0]         st;
        logic               err_check;
        logic               held;
        logic [7:0]         ack_inc;

        spd       = (jog_move_speed_reg == 16'd0) ? 17'(SPEED_DEFAULT)
                                                  : 17'(jog_move_speed_reg);
        rec_next  = cur_rec;
        pc        = cur_rec.pend | s1_pulses_reg;
        dc        = cur_rec.dcmd;
        st        = cur_rec.seq;
        err_check = 1'b0;
        held      = 1'b0;
        ack_inc   = (cur_rec.ack < ACK_COUNT_MAX) ? cur_rec.ack + 8'd1 : cur_rec.ack;

        unique case (cur_rec.seq)
            ST_POWER:
            begin
                if (s1_powered_reg)
                begin
                    dc = dc | DC_HOME;
                    st = ST_INITHOME;
                end
                err_check = 1'b1;
            end
            ST_INITHOME, ST_HOME:
            begin
                if (s1_homed_reg)
                begin
                    if (homing_ref_reg)
                    begin
                        rec_next.homed = 1'b1;
                    end
                    st = ST_READY;
                end
                err_check = 1'b1;
            end
            ST_READY:
            begin
                priority if ((pc & PC_HOME) != '0)
                begin
                    pc = pc & ~PC_HOME;
                    dc = dc | DC_HOME;
                    st = ST_HOME;
                end
                else if ((pc & PC_STOP) != '0)
                begin
                    pc = pc & ~PC_STOP;
                    dc = dc | DC_STOP;
                    st = ST_STOP;
                end
                else if ((s1_jog_reg & JOG_POS) != '0)
                begin
                    dc = dc | DC_VEL;
                    rec_next.speed = spd;
                    st = ST_JOGP;
                end
                else if ((s1_jog_reg & JOG_NEG) != '0)
                begin
                    dc = dc | DC_VEL;
                    rec_next.speed = -spd;
                    st = ST_JOGN;
                end
                else if ((pc & PC_ABS) != '0)
                begin
                    pc = pc & ~PC_ABS;
                    dc = dc | DC_ABS;
                    rec_next.pos   = s1_target_reg;
                    rec_next.speed = spd;
                    st = ST_ABS;
                end
                else if ((pc & PC_REL) != '0)
                begin
                    pc = pc & ~PC_REL;
                    dc = dc | DC_ADD;
                    rec_next.pos   = s1_target_reg;
                    rec_next.speed = spd;
                    st = ST_REL;
                end
                else
                begin
                    st = ST_READY;
                end
            end
            ST_STOP:
            begin
                if (!s1_moving_reg)
                begin
                    st = ST_READY;
                end
                err_check = 1'b1;
            end
            ST_JOGP, ST_JOGN:
            begin
                held = (cur_rec.seq == ST_JOGP) ? ((s1_jog_reg & JOG_POS) != '0)
                                                : ((s1_jog_reg & JOG_NEG) != '0);
                dc = held ? (dc | DC_VEL) : (dc & ~DC_VEL);
                rec_next.speed = (cur_rec.seq == ST_JOGP) ? spd : -spd;
                if ((pc & PC_STOP) != '0)
                begin
                    pc = pc & ~PC_STOP;
                    dc = (dc & ~DC_VEL) | DC_STOP;
                    st = ST_STOP;
                end
                else if (!held && !s1_moving_reg)
                begin
                    st = ST_READY;
                end
                err_check = 1'b1;
            end
            ST_ABS, ST_REL:
            begin
                rec_next.pos   = s1_target_reg;
                rec_next.speed = spd;
                if ((pc & PC_STOP) != '0)
                begin
                    pc = pc & ~PC_STOP;
                    dc = dc | DC_STOP;
                    st = ST_STOP;
                end
                else if (!s1_moving_reg)
                begin
                    st = ST_READY;
                end
                err_check = 1'b1;
            end
            ST_ERROR:
            begin
                if ((pc & PC_ACK) != '0)
                begin
                    rec_next.err = '0;
                    dc = dc | DC_ACK;
                    rec_next.ack = '0;
                    st = ST_ERRRESET;
                end
            end
            ST_ERRRESET:
            begin
                rec_next.ack = ack_inc;
                if ((s1_status_reg == 16'd0) || (ack_inc > ack_timeout_reg))
                begin
                    st = ST_WAIT;
                end
            end
            default:
            begin
                // Wait, and any code that cannot arise: drop everything but power.
                pc = '0;
                dc = dc & DC_POWER;
                if (s1_inited_reg && power_enable_reg)
                begin
                    dc = dc | DC_POWER;
                    st = ST_POWER;
                end
                else
                begin
                    st = ST_WAIT;
                end
            end
        endcase

        if (err_check && (s1_status_reg != 16'd0))
        begin
            rec_next.err = s1_status_reg;
            st = ST_ERROR;
        end

        rec_next.seq  = st;
        rec_next.pend = pc;
        rec_next.dcmd = dc;
        ready_next    = (rec_next.err == 16'd0) && s1_powered_reg && s1_homed_reg;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo axis motion sequencer testbench
// Drives per-axis control ticks through the valid/stall input channel, keeps
// its own per-axis copy of the sequencer to predict every output word, and
// compares the words that leave the block in order, field by field. The run
// goes through several register settings, a directed walk of the sequencer
// and biased random ticks, with random idling on both channels and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import sams_pkg::*;

    localparam int NUM_AXES = AXIS_COUNT_DEFAULT;

    typedef struct packed {
        logic [1:0]         axis;
        logic [4:0]         pulses;
        logic [1:0]         jog;
        logic signed [31:0] target;
        logic               inited;
        logic               powered;
        logic               homed;
        logic               moving;
        logic [15:0]        status;
    } tick_t;

    typedef struct packed {
        logic [1:0]         axis;
        logic [3:0]         state;
        logic [6:0]         dcmd;
        logic signed [16:0] speed;
        logic signed [31:0] pos;
        logic [15:0]        err;
        logic               ready;
        logic               homed;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         axis = '0;
    logic [4:0]         command_pulses = '0;
    logic [1:0]         jog_levels = '0;
    logic signed [31:0] target_position = '0;
    logic               drive_initialized = 1'b0;
    logic               drive_powered = 1'b0;
    logic               drive_homed = 1'b0;
    logic               drive_moving = 1'b0;
    logic [15:0]        drive_error_code = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         axis_out;
    logic [3:0]         sequencer_state;
    logic [6:0]         drive_commands;
    logic signed [16:0] drive_speed;
    logic signed [31:0] drive_position;
    logic [15:0]        error_code;
    logic               axis_ready;
    logic               home_done;

    // Predictor copy of the registers and the per-axis records.
    logic        pwr_en;
    logic [15:0] move_speed;
    logic [23:0] accel_rate;
    logic [23:0] decel_rate;
    logic        home_ref;
    logic [7:0]  ack_limit;
    axis_rec_t   axis_mem [NUM_AXES];

    tick_t   pending_ticks [$];
    report_t awaited_reports [$];
    tick_t   next_tick;
    tick_t   seen_tick;
    report_t got_report;
    report_t want_report;

    int   ticks_taken = 0;
    int   mismatch_count = 0;
    logic word_taken = 1'b0;
    logic hold_off = 1'b0;
    logic calm;

    // No idling on either side over a stretch in the middle of the run.
    assign calm = (ticks_taken >= 1000) && (ticks_taken < 1300);

    servo_axis_motion_sequencer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .axis              (axis),
        .command_pulses    (command_pulses),
        .jog_levels        (jog_levels),
        .target_position   (target_position),
        .drive_initialized (drive_initialized),
        .drive_powered     (drive_powered),
        .drive_homed       (drive_homed),
        .drive_moving      (drive_moving),
        .drive_error_code  (drive_error_code),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .axis_out          (axis_out),
        .sequencer_state   (sequencer_state),
        .drive_commands    (drive_commands),
        .drive_speed       (drive_speed),
        .drive_position    (drive_position),
        .error_code        (error_code),
        .axis_ready        (axis_ready),
        .home_done         (home_done)
    );

    always #10 clk = ~clk;

    function automatic report_t advance_axis(input tick_t t);
        axis_rec_t          r;
        report_t            rep;
        logic signed [16:0] spd;
        logic [3:0]         st;
        logic [4:0]         pc;
        logic [6:0]         dc;
        logic               held;
        logic               chk;
        r = axis_mem[t.axis];
        spd = {1'b0, (move_speed == 16'd0) ? SPEED_DEFAULT : move_speed};
        r.pend = r.pend | t.pulses;
        st = r.seq;
        pc = r.pend;
        dc = r.dcmd;
        chk = 1'b0;
        held = 1'b0;
        case (st)
            ST_POWER:
            begin
                if (t.powered)
                begin
                    dc = dc | DC_HOME;
                    st = ST_INITHOME;
                end
                chk = 1'b1;
            end
            ST_INITHOME, ST_HOME:
            begin
                if (t.homed)
                begin
                    if (home_ref)
                        r.homed = 1'b1;
                    st = ST_READY;
                end
                chk = 1'b1;
            end
            ST_READY:
            begin
                // Ready makes no error check; commands go by fixed priority.
                if ((pc & PC_HOME) != 5'd0)
                begin
                    pc = pc & ~PC_HOME;
                    dc = dc | DC_HOME;
                    st = ST_HOME;
                end
                else if ((pc & PC_STOP) != 5'd0)
                begin
                    pc = pc & ~PC_STOP;
                    dc = dc | DC_STOP;
                    st = ST_STOP;
                end
                else if ((t.jog & JOG_POS) != 2'd0)
                begin
                    dc = dc | DC_VEL;
                    r.speed = spd;
                    st = ST_JOGP;
                end
                else if ((t.jog & JOG_NEG) != 2'd0)
                begin
                    dc = dc | DC_VEL;
                    r.speed = -spd;
                    st = ST_JOGN;
                end
                else if ((pc & PC_ABS) != 5'd0)
                begin
                    pc = pc & ~PC_ABS;
                    dc = dc | DC_ABS;
                    r.pos = t.target;
                    r.speed = spd;
                    st = ST_ABS;
                end
                else if ((pc & PC_REL) != 5'd0)
                begin
                    pc = pc & ~PC_REL;
                    dc = dc | DC_ADD;
                    r.pos = t.target;
                    r.speed = spd;
                    st = ST_REL;
                end
            end
            ST_STOP:
            begin
                if (!t.moving)
                    st = ST_READY;
                chk = 1'b1;
            end
            ST_JOGP, ST_JOGN:
            begin
                held = (st == ST_JOGP) ? ((t.jog & JOG_POS) != 2'd0)
                                       : ((t.jog & JOG_NEG) != 2'd0);
                if (held)
                    dc = dc | DC_VEL;
                else
                    dc = dc & ~DC_VEL;
                r.speed = (st == ST_JOGP) ? spd : -spd;
                if ((pc & PC_STOP) != 5'd0)
                begin
                    pc = pc & ~PC_STOP;
                    dc = (dc & ~DC_VEL) | DC_STOP;
                    st = ST_STOP;
                end
                else if (!held && !t.moving)
                    st = ST_READY;
                chk = 1'b1;
            end
            ST_ABS, ST_REL:
            begin
                r.pos = t.target;
                r.speed = spd;
                if ((pc & PC_STOP) != 5'd0)
                begin
                    pc = pc & ~PC_STOP;
                    dc = dc | DC_STOP;
                    st = ST_STOP;
                end
                else if (!t.moving)
                    st = ST_READY;
                chk = 1'b1;
            end
            ST_ERROR:
            begin
                if ((pc & PC_ACK) != 5'd0)
                begin
                    r.err = 16'd0;
                    dc = dc | DC_ACK;
                    r.ack = 8'd0;
                    st = ST_ERRRESET;
                end
            end
            ST_ERRRESET:
            begin
                if (r.ack < ACK_COUNT_MAX)
                    r.ack = r.ack + 8'd1;
                if (t.status == 16'd0 || r.ack > ack_limit)
                    st = ST_WAIT;
            end
            default:
            begin
                // Wait drops every latched command except power.
                pc = 5'd0;
                dc = dc & DC_POWER;
                if (t.inited && pwr_en)
                begin
                    dc = dc | DC_POWER;
                    st = ST_POWER;
                end
                else
                    st = ST_WAIT;
            end
        endcase
        if (chk && t.status != 16'd0)
        begin
            r.err = t.status;
            st = ST_ERROR;
        end
        r.seq = st;
        r.pend = pc;
        r.dcmd = dc;
        axis_mem[t.axis] = r;
        rep.axis = t.axis;
        rep.state = st;
        rep.dcmd = dc;
        rep.speed = r.speed;
        rep.pos = r.pos;
        rep.err = r.err;
        rep.ready = (r.err == 16'd0) && t.powered && t.homed;
        rep.homed = r.homed;
        return rep;
    endfunction

    // Accepted input words feed the predictor, register writes update its copy,
    // and accepted output words are checked against the oldest prediction.
    always @(posedge clk)
    begin
        word_taken <= in_valid && !in_stall;
        if (!rst_n)
        begin
            pwr_en = 1'b1;
            move_speed = SPEED_DEFAULT;
            accel_rate = 24'd187500;
            decel_rate = 24'd187500;
            home_ref = 1'b0;
            ack_limit = ACK_TIMEOUT_RST;
            for (int i = 0; i < NUM_AXES; i++)
                axis_mem[i] = '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                seen_tick.axis = axis;
                seen_tick.pulses = command_pulses;
                seen_tick.jog = jog_levels;
                seen_tick.target = target_position;
                seen_tick.inited = drive_initialized;
                seen_tick.powered = drive_powered;
                seen_tick.homed = drive_homed;
                seen_tick.moving = drive_moving;
                seen_tick.status = drive_error_code;
                ticks_taken = ticks_taken + 1;
                if (seen_tick.axis < NUM_AXES)
                    awaited_reports.push_back(advance_axis(seen_tick));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POWER_ENABLE:   pwr_en = cfg_data[0];
                    CFG_JOG_MOVE_SPEED: move_speed = cfg_data[15:0];
                    CFG_ACCELERATION:   accel_rate = cfg_data;
                    CFG_DECELERATION:   decel_rate = cfg_data;
                    CFG_HOMING_REF:     home_ref = cfg_data[0];
                    CFG_ACK_TIMEOUT:    ack_limit = cfg_data[7:0];
                    default:            ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got_report.axis = axis_out;
                got_report.state = sequencer_state;
                got_report.dcmd = drive_commands;
                got_report.speed = drive_speed;
                got_report.pos = drive_position;
                got_report.err = error_code;
                got_report.ready = axis_ready;
                got_report.homed = home_done;
                if (awaited_reports.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("%0t: output word with nothing expected, axis %0d state %0d",
                                 $realtime, got_report.axis, got_report.state);
                end
                else
                begin
                    want_report = awaited_reports.pop_front();
                    if (got_report.axis !== want_report.axis
                        || got_report.state !== want_report.state
                        || got_report.dcmd !== want_report.dcmd
                        || got_report.speed !== want_report.speed
                        || got_report.pos !== want_report.pos
                        || got_report.err !== want_report.err
                        || got_report.ready !== want_report.ready
                        || got_report.homed !== want_report.homed)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: mismatch exp axis %0d st %0d cmd %h spd %0d pos %0d",
                                     $realtime, want_report.axis, want_report.state,
                                     want_report.dcmd, want_report.speed, want_report.pos);
                            $display("    exp err %h rdy %b hd %b", want_report.err,
                                     want_report.ready, want_report.homed);
                            $display("    got axis %0d st %0d cmd %h spd %0d pos %0d",
                                     got_report.axis, got_report.state, got_report.dcmd,
                                     got_report.speed, got_report.pos);
                            $display("    got err %h rdy %b hd %b", got_report.err,
                                     got_report.ready, got_report.homed);
                        end
                    end
                end
            end
        end
    end

    // Sender: a new word is put up only once the current one has been taken.
    always @(negedge clk)
    begin
        if (!in_valid || word_taken)
        begin
            if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= 32))
            begin
                next_tick = pending_ticks.pop_front();
                in_valid <= 1'b1;
                axis <= next_tick.axis;
                command_pulses <= next_tick.pulses;
                jog_levels <= next_tick.jog;
                target_position <= next_tick.target;
                drive_initialized <= next_tick.inited;
                drive_powered <= next_tick.powered;
                drive_homed <= next_tick.homed;
                drive_moving <= next_tick.moving;
                drive_error_code <= next_tick.status;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= hold_off || (!calm && $urandom_range(99) < 32);

    // One long receiver hold-off so that the block fills and stalls its input.
    initial
    begin
        while (ticks_taken < 300)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic tick_t mk_tick(input logic [1:0] ax, input logic [4:0] pulses,
                                      input logic [1:0] jog, input logic [31:0] target,
                                      input logic [3:0] flags, input logic [15:0] status);
        tick_t t;
        t.axis = ax;
        t.pulses = pulses;
        t.jog = jog;
        t.target = target;
        {t.inited, t.powered, t.homed, t.moving} = flags;
        t.status = status;
        return t;
    endfunction

    // Well-formed ticks keep the drive mostly healthy so that the sequencer
    // gets past power-on; noisy ticks take all fields but the axis fully at random.
    function automatic tick_t rand_tick(input logic [1:0] ax, input logic noisy);
        tick_t t;
        int    b;
        t.axis = ax;
        t.target = $urandom;
        if (noisy)
        begin
            t.pulses = 5'($urandom);
            t.jog = 2'($urandom);
            t.inited = 1'($urandom);
            t.powered = 1'($urandom);
            t.homed = 1'($urandom);
            t.moving = 1'($urandom);
            t.status = 16'($urandom);
        end
        else
        begin
            t.pulses = '0;
            for (b = 0; b < 5; b++)
                if ($urandom_range(99) < 12)
                    t.pulses[b] = 1'b1;
            t.jog = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd0;
            t.inited = ($urandom_range(9) != 0);
            t.powered = ($urandom_range(9) < 8);
            t.homed = ($urandom_range(9) < 6);
            t.moving = 1'($urandom_range(1));
            t.status = ($urandom_range(19) == 0) ? 16'($urandom_range(65535, 1)) : 16'd0;
        end
        return t;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_ticks.size() != 0 || in_valid || awaited_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++)
            pending_ticks.push_back(rand_tick(2'($urandom_range(3)),
                                              $urandom_range(9) == 0));
        drain();
    endtask

    initial
    begin
        tick_t t;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_POWER_ENABLE, 24'd1);
        write_reg(CFG_JOG_MOVE_SPEED, 24'd0);
        write_reg(CFG_ACCELERATION, 24'd0);
        write_reg(CFG_DECELERATION, 24'hFFFFFF);
        write_reg(CFG_HOMING_REF, 24'd1);
        write_reg(CFG_ACK_TIMEOUT, 24'd0);

        // Directed walk of axis 0 through every sequencer state.
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b0000, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1000, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1000, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1100, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1110, 0));
        pending_ticks.push_back(mk_tick(0, PC_HOME | PC_STOP | PC_ABS | PC_REL, 0, 0,
                                        4'b1100, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1110, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1110, 0));
        pending_ticks.push_back(mk_tick(0, 0, JOG_POS | JOG_NEG, 0, 4'b1110, 0));
        pending_ticks.push_back(mk_tick(0, 0, JOG_POS, 0, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1110, 0));
        pending_ticks.push_back(mk_tick(0, 0, JOG_NEG, 0, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, PC_STOP, JOG_NEG, 0, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1110, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 32'h7FFFFFFF, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 32'h80000000, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 32'h80000000, 4'b1110, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 32'hFFFFFFFF, 4'b1111, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1111, 16'hFFFF));
        pending_ticks.push_back(mk_tick(0, PC_ACK, 0, 0, 4'b1111, 16'hFFFF));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1111, 16'h0001));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1000, 0));
        pending_ticks.push_back(mk_tick(0, 0, 0, 0, 4'b1000, 16'h8000));
        pending_ticks.push_back(mk_tick(3, 5'h1F, 2'b11, 32'h7FFFFFFF, 4'b1111, 16'hFFFF));
        drain();

        write_reg(CFG_JOG_MOVE_SPEED, 24'd65535);
        write_reg(CFG_ACK_TIMEOUT, 24'd200);
        write_reg(CFG_HOMING_REF, 24'd0);
        write_reg(CFG_ACCELERATION, 24'd187500);
        run_random(600);

        // With power disabled an axis that reaches wait stays there.
        write_reg(CFG_POWER_ENABLE, 24'd0);
        write_reg(CFG_JOG_MOVE_SPEED, 24'd1);
        write_reg(CFG_ACK_TIMEOUT, 24'd255);
        write_reg(CFG_HOMING_REF, 24'd1);
        run_random(200);

        write_reg(CFG_POWER_ENABLE, 24'd1);
        write_reg(CFG_JOG_MOVE_SPEED, 24'd3000);
        write_reg(CFG_DECELERATION, 24'd0);
        run_random(100);
        // A long run of drive errors on one axis drives the acknowledge
        // counter into saturation, where the longest timeout never expires.
        for (int k = 0; k < 280; k++)
        begin
            t = rand_tick(3, 1'b0);
            t.inited = 1'b1;
            t.status = 16'($urandom_range(65535, 1));
            if (k < 8)
                t.pulses = PC_ACK | PC_HOME | PC_STOP;
            pending_ticks.push_back(t);
        end
        drain();

        repeat (2)
        begin
            write_reg(CFG_POWER_ENABLE, 24'd1);
            write_reg(CFG_JOG_MOVE_SPEED, 24'($urandom_range(65535)));
            write_reg(CFG_ACCELERATION, 24'($urandom));
            write_reg(CFG_DECELERATION, 24'($urandom));
            write_reg(CFG_HOMING_REF, 24'($urandom_range(1)));
            write_reg(CFG_ACK_TIMEOUT, 24'($urandom_range(255)));
            run_random(300);
        end

        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/sams_pkg.sv
hw/rtl/servo_axis_motion_sequencer.sv
tb/tb_top.sv
